[rtl/i2cram_pkg.sv]
// ----------------------------------------------------------------------------
// i2cram_pkg
// Types and constants shared by the I2C register access master.
// ----------------------------------------------------------------------------
package i2cram_pkg;

    localparam int unsigned DEV_ADDR_W   = 7;
    localparam logic [6:0]  DEV_ADDR_RST = 7'd104;

    localparam logic [1:0]  ACT_TICK  = 2'd0;
    localparam logic [1:0]  ACT_WRITE = 2'd1;
    localparam logic [1:0]  ACT_READ  = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_SDA = 5'd1,
        PH_ST_SCL = 5'd2,
        PH_W_DATA = 5'd3,
        PH_W_HIGH = 5'd4,
        PH_W_LOW  = 5'd5,
        PH_A_REL  = 5'd6,
        PH_A_HIGH = 5'd7,
        PH_A_LOW  = 5'd8,
        PH_P1_SDA = 5'd9,
        PH_P1_SCL = 5'd10,
        PH_P1_REL = 5'd11,
        PH_RS_SDA = 5'd12,
        PH_RS_SCL = 5'd13,
        PH_R_REL  = 5'd14,
        PH_R_HIGH = 5'd15,
        PH_R_LOW  = 5'd16,
        PH_N_SDA  = 5'd17,
        PH_N_HIGH = 5'd18,
        PH_N_LOW  = 5'd19,
        PH_SP_SDA = 5'd20,
        PH_SP_SCL = 5'd21,
        PH_SP_REL = 5'd22
    } phase_t;

    typedef enum logic [1:0] {
        SEL_DEV_W = 2'd0,
        SEL_REG   = 2'd1,
        SEL_DATA  = 2'd2,
        SEL_DEV_R = 2'd3
    } byte_sel_t;

    typedef struct packed {
        phase_t    phase;
        logic [3:0] bit_count;
        logic [7:0] shift_byte;
        logic       is_read;
        logic [7:0] lat_reg;
        logic [7:0] lat_data;
        logic [7:0] rx_byte;
        logic       scl;
        logic       sda;
        byte_sel_t  sel;
    } seq_state_t;

    localparam seq_state_t SEQ_STATE_RST = '{
        phase:      PH_IDLE,
        bit_count:  4'd0,
        shift_byte: 8'd0,
        is_read:    1'b0,
        lat_reg:    8'd0,
        lat_data:   8'd0,
        rx_byte:    8'd0,
        scl:        1'b1,
        sda:        1'b1,
        sel:        SEL_DEV_W
    };

endpackage

[rtl/i2cram_step.sv]
// ----------------------------------------------------------------------------
// i2cram_step
// One line change of the I2C sequence: next sequencer state from the current
// state and one transaction on the input channel.
// ----------------------------------------------------------------------------
module i2cram_step
    import i2cram_pkg::*;
(
    input  seq_state_t st,
    input  logic [1:0] action,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_data,
    input  logic       sda_in,
    input  logic [6:0] device_address,
    output seq_state_t st_next,
    output logic       done,
    output logic       nack
);

    always_comb begin
        st_next = st;
        done    = 1'b0;
        nack    = 1'b0;
        if (action == ACT_WRITE || action == ACT_READ) begin
            if (st.phase == PH_IDLE) begin
                st_next.is_read   = (action == ACT_READ);
                st_next.lat_reg   = reg_address;
                st_next.lat_data  = write_data;
                st_next.bit_count = 4'd0;
                st_next.sel       = SEL_DEV_W;
                st_next.phase     = PH_ST_SDA;
            end
        end else begin
            unique case (st.phase)
                PH_IDLE: begin
                end
                PH_ST_SDA: begin
                    st_next.sda   = 1'b0;
                    st_next.phase = PH_ST_SCL;
                end
                PH_ST_SCL: begin
                    st_next.scl        = 1'b0;
                    st_next.shift_byte = {device_address, 1'b0};
                    st_next.bit_count  = 4'd0;
                    st_next.sel        = SEL_DEV_W;
                    st_next.phase      = PH_W_DATA;
                end
                PH_W_DATA: begin
                    st_next.sda   = st.shift_byte[7];
                    st_next.phase = PH_W_HIGH;
                end
                PH_W_HIGH: begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_W_LOW;
                end
                PH_W_LOW: begin
                    st_next.scl        = 1'b0;
                    st_next.shift_byte = {st.shift_byte[6:0], 1'b0};
                    st_next.bit_count  = st.bit_count + 4'd1;
                    st_next.phase      = (st_next.bit_count >= 4'd8) ? PH_A_REL : PH_W_DATA;
                end
                PH_A_REL: begin
                    st_next.sda   = 1'b1;
                    st_next.phase = PH_A_HIGH;
                end
                PH_A_HIGH: begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_A_LOW;
                end
                PH_A_LOW: begin
                    st_next.scl = 1'b0;
                    if (sda_in) begin
                        st_next.phase = PH_IDLE;
                        done          = 1'b1;
                        nack          = 1'b1;
                    end else begin
                        unique case (st.sel)
                            SEL_DEV_W: begin
                                st_next.shift_byte = st.lat_reg;
                                st_next.bit_count  = 4'd0;
                                st_next.sel        = SEL_REG;
                                st_next.phase      = PH_W_DATA;
                            end
                            SEL_REG: begin
                                if (st.is_read) begin
                                    st_next.phase = PH_P1_SDA;
                                end else begin
                                    st_next.shift_byte = st.lat_data;
                                    st_next.bit_count  = 4'd0;
                                    st_next.sel        = SEL_DATA;
                                    st_next.phase      = PH_W_DATA;
                                end
                            end
                            SEL_DATA: begin
                                st_next.phase = PH_SP_SDA;
                            end
                            default: begin
                                st_next.phase = PH_R_REL;
                            end
                        endcase
                    end
                end
                PH_P1_SDA: begin
                    st_next.sda   = 1'b0;
                    st_next.phase = PH_P1_SCL;
                end
                PH_P1_SCL: begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_P1_REL;
                end
                PH_P1_REL: begin
                    st_next.sda   = 1'b1;
                    st_next.phase = PH_RS_SDA;
                end
                PH_RS_SDA: begin
                    st_next.sda   = 1'b0;
                    st_next.phase = PH_RS_SCL;
                end
                PH_RS_SCL: begin
                    st_next.scl        = 1'b0;
                    st_next.shift_byte = {device_address, 1'b1};
                    st_next.bit_count  = 4'd0;
                    st_next.sel        = SEL_DEV_R;
                    st_next.phase      = PH_W_DATA;
                end
                PH_R_REL: begin
                    st_next.sda        = 1'b1;
                    st_next.shift_byte = 8'd0;
                    st_next.bit_count  = 4'd0;
                    st_next.phase      = PH_R_HIGH;
                end
                PH_R_HIGH: begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_R_LOW;
                end
                PH_R_LOW: begin
                    st_next.scl        = 1'b0;
                    st_next.shift_byte = {st.shift_byte[6:0], sda_in};
                    st_next.bit_count  = st.bit_count + 4'd1;
                    st_next.phase      = (st_next.bit_count >= 4'd8) ? PH_N_SDA : PH_R_HIGH;
                end
                PH_N_SDA: begin
                    st_next.sda   = 1'b1;
                    st_next.phase = PH_N_HIGH;
                end
                PH_N_HIGH: begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_N_LOW;
                end
                PH_N_LOW: begin
                    st_next.scl   = 1'b0;
                    st_next.phase = PH_SP_SDA;
                end
                PH_SP_SDA: begin
                    st_next.sda   = 1'b0;
                    st_next.phase = PH_SP_SCL;
                end
                PH_SP_SCL: begin
                    st_next.scl   = 1'b1;
                    st_next.phase = PH_SP_REL;
                end
                PH_SP_REL: begin
                    st_next.sda = 1'b1;
                    if (st.is_read) begin
                        st_next.rx_byte = st.shift_byte;
                    end
                    st_next.phase = PH_IDLE;
                    done          = 1'b1;
                end
                default: begin
                    st_next.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Pin-level I2C master for single-register reads and writes, one line
// change per input transaction, with an APB port for the target address.
// ----------------------------------------------------------------------------
// The result of each input transaction is registered in the output register.
// Throughput: one transaction per cycle while the output register is empty
// or read; the state register is updated in the same cycle the input is taken.
// Reset: synchronous, active low; lines released, sequencer idle, output
// register empty, device address 0x68.
module i2c_register_access_master
    import i2cram_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: reg_address[7:0], write_data[15:8], sda_in[16], zero [23:17]
    input  logic [23:0] s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: scl_out[0], sda_out[1], busy_res[2], done_res[3], nack_error[4],
    //        read_data[12:5], zero [15:13]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    seq_state_t st_reg;
    seq_state_t st_next;
    logic [DEV_ADDR_W-1:0] dev_addr_reg;
    logic [15:0] m_tdata_reg;
    logic        m_tvalid_reg;
    logic        done;
    logic        nack;
    logic        s_fire;

    assign pready   = 1'b1;
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tdata  = m_tdata_reg;
    assign m_tvalid = m_tvalid_reg;
    assign prdata   = (paddr[2] == 1'b0) ? {25'd0, dev_addr_reg} : 32'd0;

    i2cram_step u_step (
        .st             (st_reg),
        .action         (s_tuser),
        .reg_address    (s_tdata[7:0]),
        .write_data     (s_tdata[15:8]),
        .sda_in         (s_tdata[16]),
        .device_address (dev_addr_reg),
        .st_next        (st_next),
        .done           (done),
        .nack           (nack)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= DEV_ADDR_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            dev_addr_reg <= pwdata[DEV_ADDR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= SEQ_STATE_RST;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= 16'd0;
        end else begin
            if (s_fire) begin
                st_reg       <= st_next;
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {3'd0, st_next.rx_byte, nack, done,
                                 st_next.phase != PH_IDLE, st_next.sda, st_next.scl};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

[rtl/i2cram_checker.sv]
// ----------------------------------------------------------------------------
// i2cram_checker
// Port-level checks on the I2C register access master, bound to the top.
// ----------------------------------------------------------------------------
module i2cram_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic [15:0] m_tdata,
    input logic        m_tvalid,
    input logic        m_tready
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // an empty output register never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("nack without done");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done while still busy");

    // abort leaves clock low and data released
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> !m_tdata[0] && m_tdata[1])
        else $error("bad line levels on abort");

endmodule

bind i2c_register_access_master i2cram_checker u_i2cram_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

[tb/i2c_access_checker.sv]
// ----------------------------------------------------------------------------
// i2c_access_checker
// Watches the input, result and APB channels of the I2C register access
// master. It keeps its own copy of the line sequencer and the device address,
// predicts one line result per accepted input transaction and compares each
// accepted result field by field, in order. APB reads of the device address
// are checked as well.
// ----------------------------------------------------------------------------
module i2c_access_checker
    import i2cram_pkg::*;
#(
    parameter logic [2:0] DEV_ADDR_REG = 3'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [23:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int unsigned mismatch_count,
    output int unsigned results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // same bit order as m_tdata[12:0]: scl in bit 0
    typedef struct packed {
        logic [7:0] rdata;
        logic       nack;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } line_result_t;

    line_result_t expected_lines[$];
    int unsigned  n_bad = 0;

    phase_t     seq;
    byte_sel_t  acking;
    logic [3:0] nbits;
    logic [7:0] shreg;
    logic [7:0] reg_l;
    logic [7:0] dat_l;
    logic [7:0] rx_last;
    logic       rd_op;
    logic       scl_lvl;
    logic       sda_lvl;
    logic [6:0] dev_addr;

    task automatic shift_out(input logic [7:0] value, input byte_sel_t which);
        shreg  = value;
        nbits  = 4'd0;
        acking = which;
        seq    = PH_W_DATA;
    endtask

    task automatic step_sequencer(input logic [1:0] act, input logic [23:0] data,
                                  output line_result_t res);
        logic sda_s;
        logic fin;
        logic nk;
        sda_s = data[16];
        fin   = 1'b0;
        nk    = 1'b0;
        if (act == ACT_WRITE || act == ACT_READ) begin
            // ignored entirely while busy
            if (seq == PH_IDLE) begin
                rd_op  = (act == ACT_READ);
                reg_l  = data[7:0];
                dat_l  = data[15:8];
                nbits  = 4'd0;
                acking = SEL_DEV_W;
                seq    = PH_ST_SDA;
            end
        end else begin
            case (seq)
                PH_ST_SDA: begin
                    sda_lvl = 1'b0;
                    seq     = PH_ST_SCL;
                end
                PH_ST_SCL: begin
                    scl_lvl = 1'b0;
                    shift_out({dev_addr, 1'b0}, SEL_DEV_W);
                end
                PH_W_DATA: begin
                    sda_lvl = shreg[7];
                    seq     = PH_W_HIGH;
                end
                PH_W_HIGH: begin
                    scl_lvl = 1'b1;
                    seq     = PH_W_LOW;
                end
                PH_W_LOW: begin
                    scl_lvl = 1'b0;
                    shreg   = shreg << 1;
                    nbits   = nbits + 4'd1;
                    seq     = (nbits >= 4'd8) ? PH_A_REL : PH_W_DATA;
                end
                PH_A_REL: begin
                    sda_lvl = 1'b1;
                    seq     = PH_A_HIGH;
                end
                PH_A_HIGH: begin
                    scl_lvl = 1'b1;
                    seq     = PH_A_LOW;
                end
                PH_A_LOW: begin
                    scl_lvl = 1'b0;
                    if (sda_s) begin
                        // missing ack: abort, no stop
                        seq = PH_IDLE;
                        fin = 1'b1;
                        nk  = 1'b1;
                    end else begin
                        case (acking)
                            SEL_DEV_W: shift_out(reg_l, SEL_REG);
                            SEL_REG: begin
                                if (rd_op)
                                    seq = PH_P1_SDA;
                                else
                                    shift_out(dat_l, SEL_DATA);
                            end
                            SEL_DATA: seq = PH_SP_SDA;
                            default:  seq = PH_R_REL;
                        endcase
                    end
                end
                PH_P1_SDA: begin
                    sda_lvl = 1'b0;
                    seq     = PH_P1_SCL;
                end
                PH_P1_SCL: begin
                    scl_lvl = 1'b1;
                    seq     = PH_P1_REL;
                end
                PH_P1_REL: begin
                    sda_lvl = 1'b1;
                    seq     = PH_RS_SDA;
                end
                PH_RS_SDA: begin
                    sda_lvl = 1'b0;
                    seq     = PH_RS_SCL;
                end
                PH_RS_SCL: begin
                    scl_lvl = 1'b0;
                    shift_out({dev_addr, 1'b1}, SEL_DEV_R);
                end
                PH_R_REL: begin
                    sda_lvl = 1'b1;
                    shreg   = 8'd0;
                    nbits   = 4'd0;
                    seq     = PH_R_HIGH;
                end
                PH_R_HIGH: begin
                    scl_lvl = 1'b1;
                    seq     = PH_R_LOW;
                end
                PH_R_LOW: begin
                    scl_lvl = 1'b0;
                    shreg   = {shreg[6:0], sda_s};
                    nbits   = nbits + 4'd1;
                    seq     = (nbits >= 4'd8) ? PH_N_SDA : PH_R_HIGH;
                end
                PH_N_SDA: begin
                    sda_lvl = 1'b1;
                    seq     = PH_N_HIGH;
                end
                PH_N_HIGH: begin
                    scl_lvl = 1'b1;
                    seq     = PH_N_LOW;
                end
                PH_N_LOW: begin
                    scl_lvl = 1'b0;
                    seq     = PH_SP_SDA;
                end
                PH_SP_SDA: begin
                    sda_lvl = 1'b0;
                    seq     = PH_SP_SCL;
                end
                PH_SP_SCL: begin
                    scl_lvl = 1'b1;
                    seq     = PH_SP_REL;
                end
                PH_SP_REL: begin
                    sda_lvl = 1'b1;
                    if (rd_op)
                        rx_last = shreg;
                    seq = PH_IDLE;
                    fin = 1'b1;
                end
                default: seq = PH_IDLE;
            endcase
        end
        res.scl   = scl_lvl;
        res.sda   = sda_lvl;
        res.busy  = (seq != PH_IDLE);
        res.done  = fin;
        res.nack  = nk;
        res.rdata = rx_last;
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            n_bad++;
            if (n_bad <= 10)
                $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        line_result_t want;
        line_result_t got;
        if (!aresetn) begin
            seq      = PH_IDLE;
            acking   = SEL_DEV_W;
            nbits    = 4'd0;
            shreg    = 8'd0;
            reg_l    = 8'd0;
            dat_l    = 8'd0;
            rx_last  = 8'd0;
            rd_op    = 1'b0;
            scl_lvl  = 1'b1;
            sda_lvl  = 1'b1;
            dev_addr = DEV_ADDR_RST;
            expected_lines.delete();
        end else begin
            if (psel && penable && pready && paddr == DEV_ADDR_REG) begin
                if (pwrite)
                    dev_addr = pwdata[6:0];
                else
                    compare_field("prdata", {25'd0, dev_addr}, prdata);
            end
            if (s_tvalid && s_tready) begin
                step_sequencer(s_tuser, s_tdata, want);
                expected_lines.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[12:0];
                if (expected_lines.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: result 0x%0h with nothing outstanding",
                                 $time, m_tdata);
                end else begin
                    want = expected_lines.pop_front();
                    compare_field("scl_out", want.scl, got.scl);
                    compare_field("sda_out", want.sda, got.sda);
                    compare_field("busy", want.busy, got.busy);
                    compare_field("done", want.done, got.done);
                    compare_field("nack_error", want.nack, got.nack);
                    compare_field("read_data", want.rdata, got.rdata);
                end
            end
        end
        mismatch_count  <= n_bad;
        results_pending <= expected_lines.size();
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the I2C register access master. Drives register
// write and read sequences tick by tick, with acks, read bits and nack aborts
// placed at the right ticks, plus ignored requests and random noise, over
// several idling phases and device addresses. Checking is in the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cram_pkg::*;

    localparam logic [2:0] DEV_ADDR_REG   = 3'd0;
    localparam logic [1:0] ACT_SPARE      = 2'd3;
    localparam int         HOLD_CYCLES    = 64;
    localparam int         WATCHDOG_LIMIT = 1000;
    localparam int         PHASE_ITEMS    = 60;
    localparam int         FLUSH_TICKS    = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = ACT_TICK;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned mismatch_count;
    int unsigned results_pending;

    int   tx_idle_pct   = 0;
    int   rx_stall_pct  = 0;
    logic rx_hold       = 1'b0;
    logic hold_done     = 1'b0;
    logic last_busy     = 1'b0;
    int   hold_count    = 0;
    int   quiet_cycles  = 0;
    int   counted_items = 0;
    int   transfers     = 0;
    int   aborts        = 0;
    int   reads         = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    i2c_register_access_master i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    i2c_access_checker #(.DEV_ADDR_REG(DEV_ADDR_REG)) i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    // result side: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (rx_hold && !hold_done) begin
            m_tready   <= 1'b0;
            hold_count <= hold_count + 1;
            if (hold_count == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
        end else begin
            if (!rx_hold) begin
                hold_count <= 0;
                hold_done  <= 1'b0;
            end
            m_tready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // busy flag of the last accepted result
    always @(posedge aclk) begin
        if (!aresetn)
            last_busy <= 1'b0;
        else if (m_tvalid && m_tready)
            last_busy <= m_tdata[2];
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] act, input logic [7:0] ra,
                             input logic [7:0] wd, input logic sda);
        int gap;
        gap = 0;
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= act;
        s_tdata  <= {7'd0, sda, wd, ra};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Request then the ticks of a whole transaction. Acks fall on ticks 29, 56
    // and 83 (write) or 88 (read address byte); nack_at picks the one to fail.
    task automatic run_transfer(input logic rd, input logic [7:0] ra,
                                input logic [7:0] wd, input int nack_at,
                                input bit busy_req);
        int   n_ticks;
        int   ack_no;
        logic sda;
        bit   cut;
        n_ticks = rd ? 111 : 86;
        cut     = 1'b0;
        send_item(rd ? ACT_READ : ACT_WRITE, ra, wd, 1'($urandom_range(1)));
        counted_items++;
        transfers++;
        if (busy_req)
            send_item(rd ? ACT_WRITE : ACT_READ, ~ra, ~wd, 1'b0);
        for (int k = 1; k <= n_ticks && !cut; k++) begin
            if ($urandom_range(99) < 3)
                send_item($urandom_range(1) ? ACT_READ : ACT_WRITE, 8'($urandom),
                          8'($urandom), 1'($urandom_range(1)));
            ack_no = (k == 29) ? 1 : (k == 56) ? 2 : (k == (rd ? 88 : 83)) ? 3 : 0;
            sda    = (ack_no == 0) ? 1'($urandom_range(1)) : (ack_no == nack_at);
            send_item(($urandom_range(9) == 0) ? ACT_SPARE : ACT_TICK, 8'($urandom),
                      8'($urandom), sda);
            counted_items++;
            if (ack_no != 0 && ack_no == nack_at) begin
                cut = 1'b1;
                aborts++;
            end
        end
        if (rd && !cut)
            reads++;
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        int start_items;
        tx_idle_pct = tx_pct;
        rx_stall_pct <= rx_pct;
        start_items = counted_items;
        if (with_hold)
            fork
                begin
                    rx_hold <= 1'b1;
                    do @(posedge aclk); while (!hold_done);
                    rx_hold <= 1'b0;
                end
                run_transfer(1'b0, 8'($urandom), 8'($urandom), 0, 1'b0);
            join
        while (counted_items - start_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85)
                run_transfer(1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                             ($urandom_range(99) < 70) ? 0 : int'($urandom_range(3, 1)),
                             1'b0);
            else
                repeat ($urandom_range(6, 1))
                    send_item(2'($urandom_range(3)), 8'($urandom), 8'($urandom),
                              1'($urandom_range(1)));
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0)
            @(posedge aclk);
        // high sda aborts or completes whatever is left in flight
        for (int k = 0; k < FLUSH_TICKS && last_busy; k++) begin
            send_item(ACT_TICK, 8'($urandom), 8'($urandom), 1'b1);
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while (results_pending != 0)
                @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= DEV_ADDR_REG;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        logic [31:0] last_addr;
        last_addr = $urandom;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        apb_access(1'b0, '0);

        // idle tick, spare action code, write aborted on the first ack with
        // an ignored read request straight after the start
        send_item(ACT_TICK, 8'h00, 8'h00, 1'b1);
        send_item(ACT_SPARE, 8'hFF, 8'hFF, 1'b0);
        run_transfer(1'b0, 8'hFF, 8'h00, 1, 1'b1);

        run_phase(0, 0, 1'b1);
        apb_access(1'b1, 32'h0000_007F);
        apb_access(1'b0, '0);
        run_phase(70, 0, 1'b0);
        apb_access(1'b1, 32'h0000_0000);
        apb_access(1'b0, '0);
        run_phase(0, 70, 1'b0);
        apb_access(1'b1, last_addr);
        apb_access(1'b0, '0);
        run_phase(12, 12, 1'b0);

        $display("Covered %0d items in %0d transactions, %0d aborted on a missing ack,",
                 counted_items, transfers, aborts);
        $display("%0d full reads, device addresses 0x68, 0x7f, 0x00 and 0x%02h, %s",
                 reads, last_addr[6:0], "under idle, stalled and held-off channels.");
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
rtl/i2cram_pkg.sv
rtl/i2cram_step.sv
rtl/i2c_register_access_master.sv
rtl/i2cram_checker.sv
tb/i2c_access_checker.sv
tb/tb_top.sv
